// ===== design/bia_pkg.sv =====
`default_nettype none

package bia_pkg;

   // Pool geometry
   localparam int MaxIds     = 4096;
   localparam int WordBits   = 64;
   localparam int KeyWidth   = 64;
   localparam int NumUnits   = MaxIds / WordBits;
   localparam int IdWidth    = $clog2(MaxIds);
   localparam int BitWidth   = $clog2(WordBits);
   localparam int UnitWidth  = $clog2(NumUnits);
   localparam int CountWidth = IdWidth + 1;
   localparam int ValueWidth = 64;

   typedef enum logic [1:0] {
      KIND_ADD     = 2'd0,
      KIND_RELEASE = 2'd1,
      KIND_REPLACE = 2'd2,
      KIND_CLEAR   = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_NOT_LIVE = 2'd1,
      STATUS_FULL     = 2'd2
   } status_type;

   typedef struct packed {
      kind_type                kind;
      logic [IdWidth-1:0]      key_id;
      logic [ValueWidth-1:0]   key_value;
   } req_type;

   typedef struct packed {
      logic [IdWidth-1:0]      given_id;
      status_type              status;
      logic [CountWidth-1:0]   live_count;
   } rsp_type;

   // Controller to datapath commands
   typedef struct packed {
      logic accept;   // latch request, launch store reads
      logic commit;   // write stores, update pool state, load result
   } ctrl_cmd_type;

endpackage

`default_nettype wire

// ===== design/bitmap_id_allocator.sv =====
`default_nettype none

// Channel   Ports                              Direction  Moves
// --------  ---------------------------------  ---------  ---------------------------------
// request   req_valid, req_stall, req_data     in         kind, key_id, key_value
// result    rsp_valid, rsp_stall, rsp_data     out        given_id, status, live_count
//
// Each request is accepted, then executed: the accept cycle launches the bitmap and link
// RAM reads, and the execute cycle writes them back and updates the list head.
// The reads of those RAMs are registered; one request runs at a time.
// Synchronous reset clears the list head, high-water mark, live count and the
// handshake state. The RAMs are not cleared: no entry's contents are used before it is written.
// A finished result waits in the result register; the next request is accepted
// meanwhile, and its execute cycle holds while the result register is full and stalled.
module bitmap_id_allocator (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire bia_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output bia_pkg::rsp_type      rsp_data
);

   bia_pkg::ctrl_cmd_type cmd;

   // sequence accept and execute, own the result valid
   bia_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd)
   );

   // bitmap, link and key stores plus free-list state
   bia_datapath u_datapath (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .req_data (req_data),
      .rsp_data (rsp_data)
   );

   // accept and execute never overlap
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(cmd.accept && cmd.commit))
      else $error("accept and commit in the same cycle");

   // an accepted request blocks the next one for the execute cycle
   a_stall_after_accept: assert property (@(posedge clock) disable iff (reset)
      cmd.accept |=> req_stall)
      else $error("request accepted during execute");

   // a result appears only after a commit
   a_valid_from_commit: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(cmd.commit))
      else $error("result valid without commit");

   // live count never exceeds the pool size
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.live_count <= bia_pkg::CountWidth'(bia_pkg::MaxIds)))
      else $error("live count beyond pool size");

endmodule

`default_nettype wire

// ===== design/bia_ram.sv =====
`default_nettype none

module bia_ram #(
   parameter int Width = 64,
   parameter int Depth = 64,
   localparam int AddrWidth = $clog2(Depth)
) (
   input  wire logic                 clock,
   input  wire logic                 wr_en,
   input  wire logic [AddrWidth-1:0] wr_addr,
   input  wire logic [Width-1:0]     wr_data,
   input  wire logic                 rd_en,
   input  wire logic [AddrWidth-1:0] rd_addr,
   output logic      [Width-1:0]     rd_data
);

   logic [Width-1:0] mem_ff [Depth];
   logic [Width-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== design/bia_ctrl.sv =====
`default_nettype none

module bia_ctrl (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output bia_pkg::ctrl_cmd_type      cmd
);

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_EXEC = 2'b10
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   // result register can take a new result this cycle
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in   = state_ff;
      cmd.accept = 1'b0;
      cmd.commit = 1'b0;
      req_stall  = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            req_stall  = 1'b0;
            cmd.accept = req_valid;
            if (req_valid) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            cmd.commit = out_free;
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = cmd.commit || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

// ===== design/bia_datapath.sv =====
`default_nettype none

module bia_datapath (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire bia_pkg::ctrl_cmd_type cmd,
   input  wire bia_pkg::req_type      req_data,
   output bia_pkg::rsp_type           rsp_data
);

   // pool control registers
   logic [bia_pkg::UnitWidth-1:0]  head_ff, head_in;
   logic                           nonempty_ff, nonempty_in;
   logic [bia_pkg::CountWidth-1:0] hw_ff, hw_in;
   logic [bia_pkg::CountWidth-1:0] total_ff, total_in;

   // request held for the execute cycle
   bia_pkg::req_type               op_ff;
   logic                           fresh_ff;
   logic [bia_pkg::UnitWidth-1:0]  unit_ff;
   bia_pkg::rsp_type               rsp_ff, rsp_in;

   logic [bia_pkg::UnitWidth-1:0]  rd_unit;

   // store ports
   logic                           bm_wr_en;
   logic [bia_pkg::WordBits-1:0]   bm_wr_data;
   logic [bia_pkg::WordBits-1:0]   bm_rd_data;
   logic                           link_wr_en;
   logic [bia_pkg::UnitWidth-1:0]  link_wr_data;
   logic [bia_pkg::UnitWidth-1:0]  link_rd_data;
   logic                           key_wr_en;
   logic [bia_pkg::IdWidth-1:0]    key_wr_addr;

   // execute-cycle datapath
   logic [bia_pkg::WordBits-1:0]   word;
   logic [bia_pkg::UnitWidth-1:0]  link;
   logic [bia_pkg::WordBits-1:0]   free_bits;
   logic [bia_pkg::WordBits-1:0]   lowest_free;
   logic [bia_pkg::BitWidth-1:0]   bit_idx;
   logic [bia_pkg::IdWidth-1:0]    new_id;
   logic [bia_pkg::CountWidth-1:0] new_id_next;
   logic [bia_pkg::WordBits-1:0]   set_word;
   logic [bia_pkg::WordBits-1:0]   rel_word;
   logic [bia_pkg::BitWidth-1:0]   op_bit;
   logic                           pool_full;
   logic                           live;

   // add uses list head if non-empty, else high-water word; others key's word
   always_comb begin
      rd_unit = req_data.key_id[bia_pkg::IdWidth-1:bia_pkg::BitWidth];
      if (req_data.kind == bia_pkg::KIND_ADD) begin
         rd_unit = nonempty_ff ? head_ff
                               : hw_ff[bia_pkg::IdWidth-1:bia_pkg::BitWidth];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         op_ff    <= req_data;
         fresh_ff <= !nonempty_ff;
         unit_ff  <= rd_unit;
      end
      if (cmd.commit) begin
         rsp_ff <= rsp_in;
      end
   end

   bia_ram #(
      .Width(bia_pkg::WordBits),
      .Depth(bia_pkg::NumUnits)
   ) u_bitmap_ram (
      .clock   (clock),
      .wr_en   (bm_wr_en),
      .wr_addr (unit_ff),
      .wr_data (bm_wr_data),
      .rd_en   (cmd.accept),
      .rd_addr (rd_unit),
      .rd_data (bm_rd_data)
   );

   bia_ram #(
      .Width(bia_pkg::UnitWidth),
      .Depth(bia_pkg::NumUnits)
   ) u_link_ram (
      .clock   (clock),
      .wr_en   (link_wr_en),
      .wr_addr (unit_ff),
      .wr_data (link_wr_data),
      .rd_en   (cmd.accept),
      .rd_addr (rd_unit),
      .rd_data (link_rd_data)
   );

   bia_ram #(
      .Width(bia_pkg::KeyWidth),
      .Depth(bia_pkg::MaxIds)
   ) u_key_ram (
      .clock   (clock),
      .wr_en   (key_wr_en),
      .wr_addr (key_wr_addr),
      .wr_data (op_ff.key_value[bia_pkg::KeyWidth-1:0]),
      .rd_en   (1'b0),
      .rd_addr ('0),
      .rd_data ()
   );

   // fresh word starts empty and links to itself
   assign word        = fresh_ff ? '0 : bm_rd_data;
   assign link        = fresh_ff ? unit_ff : link_rd_data;
   assign free_bits   = ~word;
   assign lowest_free = free_bits & (~free_bits + bia_pkg::WordBits'(1));

   always_comb begin
      bit_idx = '0;
      for (int i = 0; i < bia_pkg::WordBits; i++) begin
         if (lowest_free[i]) begin
            bit_idx = bit_idx | bia_pkg::BitWidth'(i);
         end
      end
   end

   assign new_id      = {unit_ff, bit_idx};
   assign new_id_next = {1'b0, new_id} + bia_pkg::CountWidth'(1);
   assign set_word    = word | lowest_free;
   assign pool_full   = (fresh_ff && (hw_ff >= bia_pkg::CountWidth'(bia_pkg::MaxIds)))
                        || (free_bits == '0);

   assign op_bit   = op_ff.key_id[bia_pkg::BitWidth-1:0];
   assign rel_word = bm_rd_data & ~(bia_pkg::WordBits'(1) << op_bit);
   assign live     = ({1'b0, op_ff.key_id} < hw_ff) && bm_rd_data[op_bit];

   always_comb begin
      head_in      = head_ff;
      nonempty_in  = nonempty_ff;
      hw_in        = hw_ff;
      total_in     = total_ff;
      bm_wr_en     = 1'b0;
      bm_wr_data   = set_word;
      link_wr_en   = 1'b0;
      link_wr_data = unit_ff;
      key_wr_en    = 1'b0;
      key_wr_addr  = op_ff.key_id;
      rsp_in.given_id = op_ff.key_id;
      rsp_in.status   = bia_pkg::STATUS_OK;
      case (op_ff.kind)
         bia_pkg::KIND_ADD: begin
            if (pool_full) begin
               rsp_in.status   = bia_pkg::STATUS_FULL;
               rsp_in.given_id = '0;
            end else begin
               bm_wr_en    = 1'b1;
               link_wr_en  = fresh_ff;
               key_wr_en   = 1'b1;
               key_wr_addr = new_id;
               head_in     = unit_ff;
               nonempty_in = 1'b1;
               // pop the head word once it fills
               if (set_word == '1) begin
                  if (link != unit_ff) begin
                     head_in = link;
                  end else begin
                     nonempty_in = 1'b0;
                  end
               end
               if (new_id_next > hw_ff) begin
                  hw_in = new_id_next;
               end
               total_in        = total_ff + bia_pkg::CountWidth'(1);
               rsp_in.given_id = new_id;
            end
         end
         bia_pkg::KIND_RELEASE: begin
            if (live) begin
               // a full word regains a free bit: push it on the list
               if (bm_rd_data == '1) begin
                  link_wr_en   = 1'b1;
                  link_wr_data = nonempty_ff ? head_ff : unit_ff;
                  head_in      = unit_ff;
                  nonempty_in  = 1'b1;
               end
               bm_wr_en   = 1'b1;
               bm_wr_data = rel_word;
               total_in   = total_ff - bia_pkg::CountWidth'(1);
            end else begin
               rsp_in.status = bia_pkg::STATUS_NOT_LIVE;
            end
         end
         bia_pkg::KIND_REPLACE: begin
            if (live) begin
               key_wr_en = 1'b1;
            end else begin
               rsp_in.status = bia_pkg::STATUS_NOT_LIVE;
            end
         end
         bia_pkg::KIND_CLEAR: begin
            head_in     = '0;
            nonempty_in = 1'b0;
            hw_in       = '0;
            total_in    = '0;
         end
         default: begin
            rsp_in.status = bia_pkg::STATUS_OK;
         end
      endcase
      bm_wr_en   = bm_wr_en && cmd.commit;
      link_wr_en = link_wr_en && cmd.commit;
      key_wr_en  = key_wr_en && cmd.commit;
      rsp_in.live_count = total_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff     <= '0;
         nonempty_ff <= 1'b0;
         hw_ff       <= '0;
         total_ff    <= '0;
      end else if (cmd.commit) begin
         head_ff     <= head_in;
         nonempty_ff <= nonempty_in;
         hw_ff       <= hw_in;
         total_ff    <= total_in;
      end
   end

   assign rsp_data = rsp_ff;

endmodule

`default_nettype wire
